[hw/rtl/soc_jp_pkg.sv]
// Shared types, constants and rounding helpers for the cone Jordan product block.
package soc_jp_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned FracBits = 24;
  localparam int unsigned ProdW    = 2 * DataW;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] root_x;
    logic signed [DataW-1:0] root_y;
    logic [OffsetW-1:0]      pos;
    logic                    cone_start;
    logic                    cone_end;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] z_val;
    logic [OffsetW-1:0]      entry_offset;
    logic                    saturated;
    logic                    cone_done;
  } result_t;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(result_t);

  // {saturated, z}: round half up from Q17.48 to Q8.24, then clip to 32 bits
  function automatic logic [DataW:0] round_sat(input logic signed [ProdW:0] v);
    logic signed [ProdW:0]          t;
    logic signed [ProdW-FracBits:0] r;
    logic [DataW:0]                 res;
    t = v + ((ProdW+1)'(1) <<< (FracBits - 1));
    r = t[ProdW:FracBits];
    if (r > $signed({{(ProdW-FracBits-DataW+1){1'b0}}, {1'b0, {(DataW-1){1'b1}}}})) begin
      res = {1'b1, 1'b0, {(DataW-1){1'b1}}};
    end else if (r < $signed({{(ProdW-FracBits-DataW+1){1'b1}}, {1'b1, {(DataW-1){1'b0}}}})) begin
      res = {1'b1, 1'b1, {(DataW-1){1'b0}}};
    end else begin
      res = {1'b0, r[DataW-1:0]};
    end
    return res;
  endfunction

  // 64-bit add that clips at the signed bounds
  function automatic logic signed [ProdW-1:0] sat_add64(input logic signed [ProdW-1:0] a,
                                                        input logic signed [ProdW-1:0] b);
    logic signed [ProdW:0]   s;
    logic signed [ProdW-1:0] res;
    s = {a[ProdW-1], a} + {b[ProdW-1], b};
    if (s[ProdW] != s[ProdW-1]) begin
      res = s[ProdW] ? {1'b1, {(ProdW-1){1'b0}}} : {1'b0, {(ProdW-1){1'b1}}};
    end else begin
      res = s[ProdW-1:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/soc_jordan_product_top.sv]
// Top level of the second-order cone Jordan product streaming block.
// Takes one (x, y) entry pair per cycle while the command queue is not full,
// root entry first in each cone. Each non-root entry yields its product entry;
// the cone's last entry is followed by the root result (the cone's dot product,
// cone_done set). Entries go through the command queue, the multiply stage and
// the accumulate and round stage, which writes one result per cycle unless the
// output queue is full, so a non-root entry that closes its cone holds it until
// its product and root result are both written. Values are signed Q8.24,
// rounded half up and saturated, with saturated set on clipping; entry offsets
// stop at the smaller of MAX_CONE_ORDER-1 and 1023.
module soc_jordan_product_top import soc_jp_pkg::*; #(
  parameter int unsigned MAX_CONE_ORDER = 1024,
  parameter int unsigned CMD_DEPTH      = 4,
  parameter int unsigned RES_DEPTH      = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic signed [DataW-1:0]   x_val_i,
  input  logic signed [DataW-1:0]   y_val_i,
  input  logic                      cone_start_i,
  input  logic                      cone_end_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [DataW-1:0]   z_val_o,
  output logic [OffsetW-1:0]        entry_offset_o,
  output logic                      saturated_o,
  output logic                      cone_done_o
);

  cmd_t            cmd_in, cmd_out;
  logic [CmdW-1:0] cmd_rdata;
  logic            cmd_empty, cmd_pop, accept;
  result_t         res_in, res_out;
  logic [ResW-1:0] res_rdata;
  logic            res_push, res_full;

  assign accept = push && !full;

  soc_jp_front #(
    .MAX_CONE_ORDER(MAX_CONE_ORDER)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .x_val_i     (x_val_i),
    .y_val_i     (y_val_i),
    .cone_start_i(cone_start_i),
    .cone_end_i  (cone_end_i),
    .cmd_o       (cmd_in)
  );

  soc_jp_fifo #(
    .Width(CmdW),
    .Depth(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rdata);

  soc_jp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  soc_jp_fifo #(
    .Width(ResW),
    .Depth(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_out        = result_t'(res_rdata);
  assign z_val_o        = res_out.z_val;
  assign entry_offset_o = res_out.entry_offset;
  assign saturated_o    = res_out.saturated;
  assign cone_done_o    = res_out.cone_done;

endmodule

[hw/rtl/soc_jp_fifo.sv]
// Small synchronous queue with registered storage, used between the block's parts.
module soc_jp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/soc_jp_front.sv]
// Front end: latches the cone root, tracks the entry offset and builds commands.
module soc_jp_front import soc_jp_pkg::*; #(
  parameter int unsigned MAX_CONE_ORDER = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic signed [DataW-1:0] x_val_i,
  input  logic signed [DataW-1:0] y_val_i,
  input  logic                    cone_start_i,
  input  logic                    cone_end_i,
  output cmd_t                    cmd_o
);

  localparam int unsigned PosMax   = (1 << OffsetW) - 1;
  localparam int unsigned PosLimI  = (MAX_CONE_ORDER - 1 < PosMax) ? MAX_CONE_ORDER - 1 : PosMax;
  localparam logic [OffsetW-1:0] PosLimit = OffsetW'(PosLimI);

  logic signed [DataW-1:0] root_x_q, root_x_d, root_y_q, root_y_d;
  logic [OffsetW-1:0]      pos_q, pos_d;

  always_comb begin
    if (cone_start_i) begin
      root_x_d = x_val_i;
      root_y_d = y_val_i;
      pos_d    = '0;
    end else begin
      root_x_d = root_x_q;
      root_y_d = root_y_q;
      pos_d    = (pos_q < PosLimit) ? pos_q + OffsetW'(1) : pos_q;
    end
    cmd_o.x          = x_val_i;
    cmd_o.y          = y_val_i;
    cmd_o.root_x     = root_x_d;
    cmd_o.root_y     = root_y_d;
    cmd_o.pos        = pos_d;
    cmd_o.cone_start = cone_start_i;
    cmd_o.cone_end   = cone_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_x_q <= '0;
      root_y_q <= '0;
      pos_q    <= '0;
    end else if (accept_i) begin
      root_x_q <= root_x_d;
      root_y_q <= root_y_d;
      pos_q    <= pos_d;
    end
  end

endmodule

[hw/rtl/soc_jp_back.sv]
// Back end: multiply stage, accumulate and round stage, result emission.
module soc_jp_back import soc_jp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    res_push_o,
  output result_t res_o,
  input  logic    res_full_i
);

  logic                    s1_valid_q;
  logic signed [ProdW-1:0] s1_pxy_q, s1_pa_q, s1_pb_q;
  logic [OffsetW-1:0]      s1_pos_q;
  logic                    s1_start_q, s1_end_q;
  logic                    s1_ready;

  logic                    e_valid_q, e_valid_d;
  logic                    e_nr_q, e_nr_d, e_rt_q, e_rt_d;
  logic signed [ProdW:0]   e_sum_q;
  logic [OffsetW-1:0]      e_pos_q;
  logic signed [ProdW-1:0] acc_q;
  logic                    e_done, e_take;
  logic [DataW:0]          nr_rs, rt_rs;

  assign nr_rs = round_sat(e_sum_q);
  assign rt_rs = round_sat({acc_q[ProdW-1], acc_q});

  assign res_push_o = e_valid_q && (e_nr_q || e_rt_q) && !res_full_i;
  assign e_done     = e_valid_q && ((!e_nr_q && !e_rt_q) ||
                                    (!res_full_i && (e_nr_q != e_rt_q)));
  assign e_take     = !e_valid_q || e_done;
  assign s1_ready   = !s1_valid_q || e_take;
  assign cmd_pop_o  = cmd_valid_i && s1_ready;

  always_comb begin
    if (e_nr_q) begin
      res_o.z_val        = nr_rs[DataW-1:0];
      res_o.entry_offset = e_pos_q;
      res_o.saturated    = nr_rs[DataW];
      res_o.cone_done    = 1'b0;
    end else begin
      res_o.z_val        = rt_rs[DataW-1:0];
      res_o.entry_offset = '0;
      res_o.saturated    = rt_rs[DataW];
      res_o.cone_done    = 1'b1;
    end
  end

  always_comb begin
    e_valid_d = e_valid_q;
    e_nr_d    = e_nr_q;
    e_rt_d    = e_rt_q;
    if (e_take) begin
      e_valid_d = s1_valid_q;
      e_nr_d    = !s1_start_q;
      e_rt_d    = s1_end_q;
    end else if (res_push_o) begin
      if (e_nr_q) begin
        e_nr_d = 1'b0;
      end else begin
        e_rt_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      e_valid_q  <= 1'b0;
      e_nr_q     <= 1'b0;
      e_rt_q     <= 1'b0;
      acc_q      <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= cmd_pop_o;
      end
      e_valid_q <= e_valid_d;
      e_nr_q    <= e_nr_d;
      e_rt_q    <= e_rt_d;
      if (e_take && s1_valid_q) begin
        acc_q <= s1_start_q ? s1_pxy_q : sat_add64(acc_q, s1_pxy_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_pxy_q   <= cmd_i.x * cmd_i.y;
      s1_pa_q    <= cmd_i.root_x * cmd_i.y;
      s1_pb_q    <= cmd_i.root_y * cmd_i.x;
      s1_pos_q   <= cmd_i.pos;
      s1_start_q <= cmd_i.cone_start;
      s1_end_q   <= cmd_i.cone_end;
    end
    if (e_take && s1_valid_q) begin
      e_sum_q <= {s1_pa_q[ProdW-1], s1_pa_q} + {s1_pb_q[ProdW-1], s1_pb_q};
      e_pos_q <= s1_pos_q;
    end
  end

endmodule

[sim/soc_jordan_product_top_tb.sv]
// Self-checking testbench for the cone Jordan product block: directed cones, long cone, random cones.
module soc_jordan_product_top_tb import soc_jp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxConeOrder = 1024;
  localparam logic [OffsetW-1:0] PosLimit =
      (MaxConeOrder - 1 < 1023) ? OffsetW'(MaxConeOrder - 1) : OffsetW'(1023);
  localparam logic signed [DataW-1:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic signed [DataW-1:0]   x_val_i = '0;
  logic signed [DataW-1:0]   y_val_i = '0;
  logic                      cone_start_i = 1'b0;
  logic                      cone_end_i = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [DataW-1:0]   z_val_o;
  logic [OffsetW-1:0]        entry_offset_o;
  logic                      saturated_o;
  logic                      cone_done_o;

  logic signed [DataW-1:0]   root_x_q = '0;
  logic signed [DataW-1:0]   root_y_q = '0;
  logic signed [ProdW-1:0]   dot_q = '0;
  logic [OffsetW-1:0]        pos_q = '0;

  result_t pending_products[$];
  result_t head_product;
  int      fail_count = 0;
  int      send_idle_pct = 0;
  int      pop_stall_pct = 0;

  soc_jordan_product_top #(
    .MAX_CONE_ORDER(MaxConeOrder)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .x_val_i       (x_val_i),
    .y_val_i       (y_val_i),
    .cone_start_i  (cone_start_i),
    .cone_end_i    (cone_end_i),
    .empty         (empty),
    .pop           (pop),
    .z_val_o       (z_val_o),
    .entry_offset_o(entry_offset_o),
    .saturated_o   (saturated_o),
    .cone_done_o   (cone_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t round_to_q824(input logic signed [ProdW:0] v,
                                            input logic [OffsetW-1:0] offset,
                                            input logic done);
    logic signed [ProdW:0]          t;
    logic signed [ProdW-FracBits:0] r;
    result_t                        res;
    t = v + (65'sd1 <<< (FracBits - 1));
    r = t[ProdW:FracBits];
    res.entry_offset = offset;
    res.cone_done    = done;
    res.saturated    = 1'b0;
    if (r > 41'sd2147483647) begin
      res.z_val     = QMax;
      res.saturated = 1'b1;
    end else if (r < -41'sd2147483648) begin
      res.z_val     = QMin;
      res.saturated = 1'b1;
    end else begin
      res.z_val = r[DataW-1:0];
    end
    return res;
  endfunction

  task automatic jordan_step(input logic signed [DataW-1:0] x, input logic signed [DataW-1:0] y,
                             input logic st, input logic en);
    logic signed [ProdW-1:0] xy;
    logic signed [ProdW-1:0] p1;
    logic signed [ProdW-1:0] p2;
    logic signed [ProdW:0]   acc;
    xy = ProdW'(x) * ProdW'(y);
    if (st) begin
      root_x_q = x;
      root_y_q = y;
      dot_q    = xy;
      pos_q    = '0;
    end else begin
      acc = {dot_q[ProdW-1], dot_q} + {xy[ProdW-1], xy};
      if (acc[ProdW] != acc[ProdW-1]) begin
        dot_q = acc[ProdW] ? {1'b1, {(ProdW-1){1'b0}}} : {1'b0, {(ProdW-1){1'b1}}};
      end else begin
        dot_q = acc[ProdW-1:0];
      end
      if (pos_q < PosLimit) begin
        pos_q = pos_q + 1'b1;
      end
      p1 = ProdW'(root_x_q) * ProdW'(y);
      p2 = ProdW'(root_y_q) * ProdW'(x);
      pending_products.push_back(round_to_q824({p1[ProdW-1], p1} + {p2[ProdW-1], p2},
                                               pos_q, 1'b0));
    end
    if (en) begin
      pending_products.push_back(round_to_q824({dot_q[ProdW-1], dot_q}, '0, 1'b1));
    end
  endtask

  // hold the request until it is taken, then predict its results
  task automatic push_entry(input logic signed [DataW-1:0] x, input logic signed [DataW-1:0] y,
                            input logic st, input logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    x_val_i      <= x;
    y_val_i      <= y;
    cone_start_i <= st;
    cone_end_i   <= en;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    jordan_step(x, y, st, en);
  endtask

  function automatic logic signed [DataW-1:0] rand_q824();
    int v;
    case ($urandom_range(7))
      0: rand_q824 = QMax;
      1: rand_q824 = QMin;
      2: begin
        v = int'($urandom_range(0, 67108864)) - 33554432;
        rand_q824 = v;
      end
      3: begin
        v = int'($urandom_range(0, 255)) - 128;
        rand_q824 = v;
      end
      default: rand_q824 = $urandom();
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_products.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result: z=%h off=%0d sat=%b done=%b",
                   z_val_o, entry_offset_o, saturated_o, cone_done_o);
        end
        fail_count++;
      end else begin
        head_product = pending_products.pop_front();
        if (z_val_o !== head_product.z_val || entry_offset_o !== head_product.entry_offset ||
            saturated_o !== head_product.saturated || cone_done_o !== head_product.cone_done) begin
          if (fail_count < 10) begin
            $display("mismatch: expected z=%h off=%0d sat=%b done=%b, got z=%h off=%0d sat=%b done=%b",
                     head_product.z_val, head_product.entry_offset, head_product.saturated,
                     head_product.cone_done, z_val_o, entry_offset_o, saturated_o, cone_done_o);
          end
          fail_count++;
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic test_entries_before_root();
    push_entry(QMax, QMin, 1'b0, 1'b0);
    push_entry(32'sd123, -32'sd5, 1'b0, 1'b1);
  endtask

  task automatic test_field_extremes();
    push_entry(QMax, QMax, 1'b1, 1'b0);
    push_entry(QMin, QMin, 1'b0, 1'b0);
    push_entry(QMax, QMin, 1'b0, 1'b0);
    push_entry(32'sd0, 32'sd0, 1'b0, 1'b0);
    push_entry(-32'sd1, 32'sd1, 1'b0, 1'b1);
  endtask

  task automatic test_rounding_ties();
    push_entry(32'sd1, 32'sd1, 1'b1, 1'b0);
    push_entry(32'sd0, 32'sh0080_0000, 1'b0, 1'b0);
    push_entry(32'sd0, -32'sh0080_0000, 1'b0, 1'b1);
  endtask

  task automatic test_one_entry_cone();
    push_entry(32'sh0100_0000, -32'sh0200_0000, 1'b1, 1'b1);
    push_entry(QMin, QMin, 1'b1, 1'b1);
  endtask

  task automatic test_continue_after_end();
    push_entry(32'sh0100_0000, 32'sh0200_0000, 1'b1, 1'b0);
    push_entry(32'sh0030_0000, -32'sh0110_0000, 1'b0, 1'b1);
    push_entry(-32'sh0400_0000, 32'sh0001_0000, 1'b0, 1'b1);
    push_entry(32'sh0000_0abc, 32'sh7000_0000, 1'b0, 1'b0);
    push_entry(32'sh0123_4567, -32'sh0765_4321, 1'b0, 1'b1);
  endtask

  task automatic test_accum_overflow();
    push_entry(QMin, QMin, 1'b1, 1'b0);
    push_entry(QMin, QMin, 1'b0, 1'b0);
    push_entry(QMin, QMin, 1'b0, 1'b0);
    push_entry(QMax, QMin, 1'b0, 1'b1);
    push_entry(QMin, QMax, 1'b1, 1'b0);
    push_entry(QMin, QMax, 1'b0, 1'b0);
    push_entry(QMin, QMax, 1'b0, 1'b1);
  endtask

  task automatic test_long_cone();
    push_entry(rand_q824(), rand_q824(), 1'b1, 1'b0);
    for (int i = 1; i < 256; i++) begin
      push_entry(rand_q824(), rand_q824(), 1'b0, i == 255);
    end
  endtask

  task automatic test_random_cones(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        push_entry(rand_q824(), rand_q824(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          push_entry(rand_q824(), rand_q824(), i == 0, i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_entries_before_root();
    test_field_extremes();
    test_rounding_ties();
    test_one_entry_cone();
    test_continue_after_end();
    test_accum_overflow();
    pop_stall_pct = 64;
    test_long_cone();
    pop_stall_pct = 0;
    test_random_cones(60);
    send_idle_pct = 64;
    test_random_cones(60);
    send_idle_pct = 0;
    pop_stall_pct = 64;
    test_random_cones(60);
    send_idle_pct = 37;
    pop_stall_pct = 37;
    test_random_cones(60);
    push <= 1'b0;
    while (pending_products.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("soc_jordan_product_top_tb OK");
    end else begin
      $display("soc_jordan_product_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("soc_jordan_product_top_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/soc_jp_pkg.sv
hw/rtl/soc_jp_fifo.sv
hw/rtl/soc_jp_front.sv
hw/rtl/soc_jp_back.sv
hw/rtl/soc_jordan_product_top.sv
sim/soc_jordan_product_top_tb.sv
